// ===== sv/m3ms_pkg.sv =====
// ----------------------------------------------------------------------------
// m3ms_pkg
// Shared widths, depths, types and the median helper for the median-of-three
// moving sum filter.
// ----------------------------------------------------------------------------
package m3ms_pkg;

	localparam int SAMPLE_W    = 18;
	localparam int SUM_W       = 24;
	localparam int LEN_W       = 6;
	localparam int MAX_WINDOW  = 48;
	localparam int RING_DEPTH  = MAX_WINDOW + 1;
	localparam int SLOT_W      = $clog2(RING_DEPTH);
	localparam int MEDIAN_TAPS = 3;
	localparam int MSLOT_W     = 2;
	localparam int OUT_DEPTH   = 4;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCNT_W      = OPTR_W + 1;

	localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(21);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    sum_t;

	// one sample (raw or filtered) moving between the front and back parts
	typedef struct packed {
		logic    valid;
		sample_t sample;
	} item_t;

	// one finished result
	typedef struct packed {
		sum_t    running_sum;
		sample_t filtered_sample;
		logic    window_ready;
	} result_t;

	function automatic sample_t mid_of_three(input sample_t a, input sample_t b,
			input sample_t c);
		sample_t lo;
		sample_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) begin
			return lo;
		end else if (c >= hi) begin
			return hi;
		end
		return c;
	endfunction

endpackage

// ===== sv/median3_moving_sum_filter.sv =====
// ----------------------------------------------------------------------------
// median3_moving_sum_filter
// Median-of-three filter followed by a moving sum over a configurable window.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive pressure and raise push; the sample is transferred at
//   a rising edge with push high and full low.
//   Result queue: while empty is low the oldest result (running_sum,
//   filtered_sample, window_ready) is on the ports; pop high at a rising edge
//   transfers it.
//   window_length is written at any edge with window_length_we high; change
//   it only while no results are outstanding. Values above 48 act as 48.
//   Path: middle queue, stage-one registers, result queue. Throughput: one
//   sample per cycle while results are popped; the window ring has one write
//   and one read port and both are used once per sample.
//   Reset: the median ring, window index, sum and ready flag clear at once;
//   the window ring is tracked by per-slot valid bits, so there is no
//   clearing pass and samples are taken straight after reset.
//   Stall: up to four results wait in the result queue and two samples in the
//   middle queue; beyond that full rises until pop resumes.
// ----------------------------------------------------------------------------
module median3_moving_sum_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [m3ms_pkg::SAMPLE_W-1:0]   pressure,
	output logic                            empty,
	input  logic                            pop,
	output logic [m3ms_pkg::SUM_W-1:0]      running_sum,
	output logic [m3ms_pkg::SAMPLE_W-1:0]   filtered_sample,
	output logic                            window_ready,
	input  logic                            window_length_we,
	input  logic [m3ms_pkg::LEN_W-1:0]      window_length
);

	m3ms_pkg::item_t   enq;
	m3ms_pkg::item_t   head;
	m3ms_pkg::result_t result;
	logic              deq;
	logic              accept;

	assign accept = push && !full;

	m3ms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.pressure (pressure),
		.enq      (enq)
	);

	m3ms_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (enq),
		.deq    (deq),
		.head   (head),
		.full   (full)
	);

	m3ms_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_length_we (window_length_we),
		.window_length    (window_length),
		.head             (head),
		.deq              (deq),
		.pop              (pop),
		.empty            (empty),
		.result           (result)
	);

	assign running_sum     = result.running_sum;
	assign filtered_sample = result.filtered_sample;
	assign window_ready    = result.window_ready;

endmodule

// ===== sv/m3ms_front.sv =====
// ----------------------------------------------------------------------------
// m3ms_front
// Median-of-three stage: keeps the three-entry sample ring; each accepted
// sample goes to the middle queue raw until the ring fills, then filtered.
// ----------------------------------------------------------------------------
module m3ms_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  m3ms_pkg::sample_t   pressure,
	output m3ms_pkg::item_t     enq
);

	m3ms_pkg::sample_t                     ring_q [m3ms_pkg::MEDIAN_TAPS];
	logic [m3ms_pkg::MSLOT_W-1:0]          mslot_q;
	logic                                  mfull_q;

	logic [m3ms_pkg::MSLOT_W-1:0]          slot;
	logic [m3ms_pkg::MSLOT_W-1:0]          slot_nxt;
	logic                                  last_tap;
	logic                                  full_nxt;
	m3ms_pkg::sample_t                     tap [m3ms_pkg::MEDIAN_TAPS];

	// pick the slot to write, wrapping after the last tap
	always_comb begin
		slot = (mslot_q >= m3ms_pkg::MSLOT_W'(m3ms_pkg::MEDIAN_TAPS)) ? '0 : mslot_q;
		last_tap = (slot == m3ms_pkg::MSLOT_W'(m3ms_pkg::MEDIAN_TAPS - 1));
		slot_nxt = last_tap ? '0 : slot + m3ms_pkg::MSLOT_W'(1);
		full_nxt = mfull_q | last_tap;
	end

	// ring as it stands once the new sample is in
	always_comb begin
		for (int i = 0; i < m3ms_pkg::MEDIAN_TAPS; i++) begin
			tap[i] = (slot == m3ms_pkg::MSLOT_W'(i)) ? pressure : ring_q[i];
		end
	end

	// pass the raw sample until the ring has filled
	always_comb begin
		enq.valid  = accept;
		enq.sample = full_nxt ? m3ms_pkg::mid_of_three(tap[0], tap[1], tap[2]) : pressure;
	end

	// advance the ring on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mslot_q <= '0;
			mfull_q <= 1'b0;
			for (int i = 0; i < m3ms_pkg::MEDIAN_TAPS; i++) begin
				ring_q[i] <= '0;
			end
		end else if (accept) begin
			mslot_q <= slot_nxt;
			mfull_q <= full_nxt;
			for (int i = 0; i < m3ms_pkg::MEDIAN_TAPS; i++) begin
				ring_q[i] <= tap[i];
			end
		end
	end

endmodule

// ===== sv/m3ms_queue.sv =====
// ----------------------------------------------------------------------------
// m3ms_queue
// Two-entry queue between the median stage and the window stage; it holds up to
// two samples while the window stage stalls and raises full when both are taken.
// ----------------------------------------------------------------------------
module m3ms_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  m3ms_pkg::item_t enq,
	input  logic            deq,
	output m3ms_pkg::item_t head,
	output logic            full
);

	m3ms_pkg::sample_t mem_q [2];
	logic              wptr_q;
	logic              rptr_q;
	logic [1:0]        cnt_q;

	assign full        = (cnt_q == 2'd2);
	assign head.valid  = (cnt_q != 2'd0);
	assign head.sample = mem_q[rptr_q];

	// hold the entries; no reset needed on the data
	always_ff @(posedge clk) begin
		if (enq.valid) begin
			mem_q[wptr_q] <= enq.sample;
		end
	end

	// advance pointers and occupancy on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (enq.valid) begin
				wptr_q <= ~wptr_q;
			end
			if (deq) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(enq.valid) - 2'(deq);
		end
	end

endmodule

// ===== sv/m3ms_back.sv =====
// ----------------------------------------------------------------------------
// m3ms_back
// Window stage: writes filtered samples into the window ring, keeps the
// running sum and the ready flag, and queues finished results.
// ----------------------------------------------------------------------------
module m3ms_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            window_length_we,
	input  logic [m3ms_pkg::LEN_W-1:0]      window_length,
	input  m3ms_pkg::item_t                 head,
	output logic                            deq,
	input  logic                            pop,
	output logic                            empty,
	output m3ms_pkg::result_t               result
);

	localparam logic [m3ms_pkg::SLOT_W-1:0] MaxSlot = m3ms_pkg::SLOT_W'(m3ms_pkg::MAX_WINDOW);

	// configuration and window state
	logic [m3ms_pkg::LEN_W-1:0]      len_q;
	logic [m3ms_pkg::SLOT_W-1:0]     slot_q;
	logic                            ready_q;
	m3ms_pkg::sum_t                  sum_q;
	logic [m3ms_pkg::RING_DEPTH-1:0] wvalid_q;
	m3ms_pkg::sample_t               ring_mem [m3ms_pkg::RING_DEPTH];

	// stage one: read data of the slot leaving the window
	logic                            valid_s1;
	m3ms_pkg::sample_t               rd_s1;
	logic                            rdv_s1;
	logic                            byp_s1;
	m3ms_pkg::sample_t               filt_s1;
	logic                            ready_s1;

	// result queue
	m3ms_pkg::result_t               oq_q [m3ms_pkg::OUT_DEPTH];
	logic [m3ms_pkg::OPTR_W-1:0]     owptr_q;
	logic [m3ms_pkg::OPTR_W-1:0]     orptr_q;
	logic [m3ms_pkg::OCNT_W-1:0]     ocnt_q;

	logic [m3ms_pkg::SLOT_W-1:0]     len_eff;
	logic [m3ms_pkg::SLOT_W-1:0]     slot_eff;
	logic [m3ms_pkg::SLOT_W-1:0]     slot_nxt;
	logic                            wrap;
	logic                            room;
	logic                            take;
	m3ms_pkg::sample_t               sub;
	m3ms_pkg::sum_t                  sum_nxt;
	m3ms_pkg::result_t               res_new;

	// saturate the length and step the window index
	always_comb begin
		len_eff  = (m3ms_pkg::SLOT_W'(len_q) > MaxSlot) ? MaxSlot : m3ms_pkg::SLOT_W'(len_q);
		slot_eff = (slot_q > MaxSlot) ? '0 : slot_q;
		wrap     = (slot_eff >= len_eff);
		slot_nxt = wrap ? '0 : slot_eff + m3ms_pkg::SLOT_W'(1);
	end

	// issue only when the result queue has a place for it
	assign room  = ((ocnt_q + m3ms_pkg::OCNT_W'(valid_s1)) < m3ms_pkg::OCNT_W'(m3ms_pkg::OUT_DEPTH));
	assign take  = head.valid && room;
	assign deq   = take;
	assign empty = (ocnt_q == '0);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= m3ms_pkg::WINDOW_RESET;
		end else if (window_length_we) begin
			len_q <= window_length;
		end
	end

	// window ring: write the new slot, read the slot leaving next
	always_ff @(posedge clk) begin
		if (take) begin
			ring_mem[slot_eff] <= head.sample;
			rd_s1              <= ring_mem[slot_nxt];
			rdv_s1             <= wvalid_q[slot_nxt];
			byp_s1             <= (slot_nxt == slot_eff);
			filt_s1            <= head.sample;
		end
	end

	// index, valid bits, ready flag and stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			ready_q  <= 1'b0;
			wvalid_q <= '0;
			valid_s1 <= 1'b0;
			ready_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (take) begin
				slot_q             <= slot_nxt;
				ready_q            <= ready_q | wrap;
				ready_s1           <= ready_q | wrap;
				wvalid_q[slot_eff] <= 1'b1;
			end
		end
	end

	// add the new sample, drop the one leaving; a slot never written reads zero
	always_comb begin
		if (byp_s1) begin
			sub = filt_s1;
		end else if (rdv_s1) begin
			sub = rd_s1;
		end else begin
			sub = '0;
		end
		sum_nxt = sum_q + m3ms_pkg::SUM_W'(filt_s1) - m3ms_pkg::SUM_W'(sub);
		res_new.running_sum     = sum_nxt;
		res_new.filtered_sample = filt_s1;
		res_new.window_ready    = ready_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s1) begin
			sum_q <= sum_nxt;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[owptr_q] <= res_new;
		end
	end

	// result queue pointers; drop the head on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (valid_s1) begin
				owptr_q <= owptr_q + m3ms_pkg::OPTR_W'(1);
			end
			if (pop && !empty) begin
				orptr_q <= orptr_q + m3ms_pkg::OPTR_W'(1);
			end
			ocnt_q <= ocnt_q + m3ms_pkg::OCNT_W'(valid_s1) - m3ms_pkg::OCNT_W'(pop && !empty);
		end
	end

	assign result = oq_q[orptr_q];

endmodule

// ===== sv/m3ms_checker.sv =====
// ----------------------------------------------------------------------------
// m3ms_checker
// Port-level checks for the median-of-three moving sum filter.
// ----------------------------------------------------------------------------
module m3ms_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            push,
	input logic                            full,
	input logic                            empty,
	input logic                            pop,
	input logic [m3ms_pkg::SUM_W-1:0]      running_sum,
	input logic [m3ms_pkg::SAMPLE_W-1:0]   filtered_sample,
	input logic                            window_ready
);

	// while reset is held the result queue reads empty and the input side not full
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not empty during reset");

	// a result shown with the window ready is followed by one that shows it too, or by an empty queue
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && window_ready) |=> (empty || window_ready))
		else $error("window_ready fell without reset");

	// a waiting result holds until it is transferred
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(running_sum)
			&& $stable(filtered_sample) && $stable(window_ready)))
		else $error("result changed while waiting");

	// the input side only fills up on a sample transfer
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose with no sample transferred");

endmodule

bind median3_moving_sum_filter m3ms_checker u_m3ms_checker (.*);
